// ===== hdl/gf2pa_pkg.sv =====
// Package for the GF(2) polynomial ALU: field widths, opcodes, stage sizing
// and the control struct that rides down the pipeline. No dependencies.
`default_nettype none

package gf2pa_pkg;

    localparam int OperandWidthDefault = 32;
    localparam int OperandFieldWidth   = 32;
    localparam int ResultWidth         = 63;
    localparam int OpcodeWidth         = 2;
    localparam int StepsPerStage       = 8;

    typedef logic [OpcodeWidth-1:0] opcode_t;

    localparam opcode_t OP_ADD = 2'd0;
    localparam opcode_t OP_MUL = 2'd1;
    localparam opcode_t OP_REM = 2'd2;
    localparam opcode_t OP_QUO = 2'd3;

    typedef struct packed {
        opcode_t op;
        logic    dz;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/gf2pa_req_if.sv =====
// Request channel of the GF(2) polynomial ALU: valid/ready plus opcode and operands.
// Depends on gf2pa_pkg.
`default_nettype none

interface gf2pa_req_if
    import gf2pa_pkg::*;
();
    logic                         valid;
    logic                         ready;
    opcode_t                      opcode;
    logic [OperandFieldWidth-1:0] operand_a;
    logic [OperandFieldWidth-1:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/gf2pa_rsp_if.sv =====
// Result channel of the GF(2) polynomial ALU: valid/ready plus result and error flag.
// Depends on gf2pa_pkg.
`default_nettype none

interface gf2pa_rsp_if
    import gf2pa_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [ResultWidth-1:0] poly_result;
    logic                   divide_by_zero;

    modport source (output valid, output poly_result, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input poly_result, input divide_by_zero,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/gf2pa_prep.sv =====
// Entry stage: mask operands, find the divisor degree; for rem/quo normalize
// divisor and dividend so the divisor MSB is at W-1. Depends on gf2pa_pkg.
`default_nettype none

module gf2pa_prep
    import gf2pa_pkg::*;
#(
    parameter int W = OperandWidthDefault
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         up_valid,
    output logic                              up_ready,
    input  wire opcode_t                      up_opcode,
    input  wire logic [OperandFieldWidth-1:0] up_operand_a,
    input  wire logic [OperandFieldWidth-1:0] up_operand_b,
    output logic                              down_valid,
    input  wire logic                         down_ready,
    output ctrl_t                             down_ctrl,
    output logic [2*W-2:0]                    down_work,
    output logic [W-1:0]                      down_x,
    output logic [W-1:0]                      down_y,
    output logic [$clog2(W)-1:0]              down_s
);

    localparam int SW = $clog2(W);

    logic               valid_reg;
    ctrl_t              ctrl_reg, ctrl_next;
    logic [2*W-2:0]     work_reg, work_next;
    logic [W-1:0]       x_reg, x_next;
    logic [W-1:0]       y_reg, y_next;
    logic [SW-1:0]      s_reg, s_next;

    logic [W-1:0]       a;
    logic [W-1:0]       b;
    logic [SW-1:0]      db;

    assign a = up_operand_a[W-1:0];
    assign b = up_operand_b[W-1:0];

    // Degree of the divisor: highest set bit.
    always_comb
    begin
        db = '0;
        for (int i = 0; i < W; i++)
        begin
            if (b[i])
            begin
                db = SW'(i);
            end
        end
    end

    always_comb
    begin
        ctrl_next.op = up_opcode;
        ctrl_next.dz = up_opcode[1] && (b == '0);
        s_next       = SW'(W - 1) - db;
        unique case (up_opcode)
            OP_ADD:
            begin
                work_next = {{(W-1){1'b0}}, a ^ b};
                x_next    = a;
                y_next    = b;
            end
            OP_MUL:
            begin
                work_next = '0;
                x_next    = a;
                y_next    = b;
            end
            default:
            begin
                // Dividend and divisor both scaled by x^s.
                work_next = {{(W-1){1'b0}}, a} << s_next;
                x_next    = b << s_next;
                y_next    = '0;
            end
        endcase
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctrl_reg <= ctrl_next;
            work_reg <= work_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            s_reg    <= s_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_ctrl  = ctrl_reg;
    assign down_work  = work_reg;
    assign down_x     = x_reg;
    assign down_y     = y_reg;
    assign down_s     = s_reg;

endmodule

`default_nettype wire

// ===== hdl/gf2pa_step.sv =====
// One pipeline stage of StepsPerStage steps: partial products for multiply,
// shift-and-subtract long division steps for remainder/quotient. Depends on gf2pa_pkg.
`default_nettype none

module gf2pa_step
    import gf2pa_pkg::*;
#(
    parameter int W    = OperandWidthDefault,
    parameter int BASE = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire ctrl_t                up_ctrl,
    input  wire logic [2*W-2:0]       up_work,
    input  wire logic [W-1:0]         up_x,
    input  wire logic [W-1:0]         up_y,
    input  wire logic [$clog2(W)-1:0] up_s,
    output logic                      down_valid,
    input  wire logic                 down_ready,
    output ctrl_t                     down_ctrl,
    output logic [2*W-2:0]            down_work,
    output logic [W-1:0]              down_x,
    output logic [W-1:0]              down_y,
    output logic [$clog2(W)-1:0]      down_s
);

    localparam int SW = $clog2(W);

    logic           valid_reg;
    ctrl_t          ctrl_reg;
    logic [2*W-2:0] work_reg, work_next;
    logic [W-1:0]   x_reg;
    logic [W-1:0]   y_reg, y_next;
    logic [SW-1:0]  s_reg;

    always_comb
    begin
        logic top;
        top       = 1'b0;
        work_next = up_work;
        y_next    = up_y;
        for (int k = 0; k < StepsPerStage; k++)
        begin
            if (BASE + k < W)
            begin
                if (up_ctrl.op == OP_MUL)
                begin
                    // Add in a * x^i where bit i of b is set.
                    if (up_y[BASE + k])
                    begin
                        work_next = work_next ^ ({{(W-1){1'b0}}, up_x} << (BASE + k));
                    end
                end
                else if (up_ctrl.op[1])
                begin
                    // Subtract the aligned divisor when the top bit is set.
                    top = work_next[2*W-2];
                    if (top)
                    begin
                        work_next = work_next ^ {up_x, {(W-1){1'b0}}};
                    end
                    work_next = {work_next[2*W-3:0], 1'b0};
                    y_next    = {y_next[W-2:0], top};
                end
            end
        end
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctrl_reg <= up_ctrl;
            work_reg <= work_next;
            x_reg    <= up_x;
            y_reg    <= y_next;
            s_reg    <= up_s;
        end
    end

    assign down_valid = valid_reg;
    assign down_ctrl  = ctrl_reg;
    assign down_work  = work_reg;
    assign down_x     = x_reg;
    assign down_y     = y_reg;
    assign down_s     = s_reg;

endmodule

`default_nettype wire

// ===== hdl/gf2pa_finish.sv =====
// Output stage: pick the result by opcode, undo the remainder normalization,
// and hold it in the output register. Depends on gf2pa_pkg.
`default_nettype none

module gf2pa_finish
    import gf2pa_pkg::*;
#(
    parameter int W = OperandWidthDefault
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire ctrl_t                up_ctrl,
    input  wire logic [2*W-2:0]       up_work,
    input  wire logic [W-1:0]         up_y,
    input  wire logic [$clog2(W)-1:0] up_s,
    output logic                      down_valid,
    input  wire logic                 down_ready,
    output logic [ResultWidth-1:0]    down_result,
    output logic                      down_dz
);

    logic                   valid_reg;
    logic [ResultWidth-1:0] result_reg, result_next;
    logic                   dz_reg;
    logic [W-2:0]           rem;
    logic [2*W-2:0]         poly;

    // Remainder sits in the top W-1 bits, scaled by x^s.
    assign rem = up_work[2*W-2:W] >> up_s;

    always_comb
    begin
        unique case (up_ctrl.op)
            OP_ADD,
            OP_MUL: poly = up_work;
            OP_REM: poly = {{W{1'b0}}, rem};
            OP_QUO: poly = {{(W-1){1'b0}}, up_y};
            default: poly = '0;
        endcase
        if (up_ctrl.dz)
        begin
            poly = '0;
        end
        result_next = ResultWidth'(poly);
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            result_reg <= result_next;
            dz_reg     <= up_ctrl.dz;
        end
    end

    assign down_valid  = valid_reg;
    assign down_result = result_reg;
    assign down_dz     = dz_reg;

endmodule

`default_nettype wire

// ===== hdl/gf2_polynomial_alu.sv =====
// Top level of the GF(2) polynomial ALU: add, carry-less multiply, remainder, quotient.
// Depends on gf2pa_pkg, gf2pa_req_if, gf2pa_rsp_if, gf2pa_prep, gf2pa_step, gf2pa_finish.
//
//   channel | dir | transfer payload
//   --------+-----+------------------------------------------------------
//   req     | in  | opcode[1:0], operand_a[31:0], operand_b[31:0]
//   rsp     | out | poly_result[62:0], divide_by_zero
//
// One transfer in per cycle while rsp is not stalled, one result per request, in order.
// Pipeline: one entry stage that normalizes the divisor, then stages of eight
// division steps or eight partial products each, then the output register.
// Stage depth is set by those eight steps.
// rst_n clears only the stage valid bits; payload registers are not reset.
// A stall on rsp backs up through the per-stage ready chain; bubbles are squeezed out.
`default_nettype none

module gf2_polynomial_alu
    import gf2pa_pkg::*;
#(
    parameter int OPERAND_WIDTH = OperandWidthDefault
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gf2pa_req_if.sink   req,
    gf2pa_rsp_if.source rsp
);

    localparam int W       = OPERAND_WIDTH;
    localparam int SW      = $clog2(W);
    localparam int NSTAGES = (W + StepsPerStage - 1) / StepsPerStage;

    // Pipe between stages: index 0 is the entry stage output.
    logic           pipe_valid [NSTAGES+1];
    logic           pipe_ready [NSTAGES+1];
    ctrl_t          pipe_ctrl  [NSTAGES+1];
    logic [2*W-2:0] pipe_work  [NSTAGES+1];
    logic [W-1:0]   pipe_x     [NSTAGES+1];
    logic [W-1:0]   pipe_y     [NSTAGES+1];
    logic [SW-1:0]  pipe_s     [NSTAGES+1];

    gf2pa_prep #(.W(W)) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (req.valid),
        .up_ready     (req.ready),
        .up_opcode    (req.opcode),
        .up_operand_a (req.operand_a),
        .up_operand_b (req.operand_b),
        .down_valid   (pipe_valid[0]),
        .down_ready   (pipe_ready[0]),
        .down_ctrl    (pipe_ctrl[0]),
        .down_work    (pipe_work[0]),
        .down_x       (pipe_x[0]),
        .down_y       (pipe_y[0]),
        .down_s       (pipe_s[0])
    );

    // Step stages: each advances eight bit positions of multiplier or quotient.
    for (genvar g = 0; g < NSTAGES; g++)
    begin : g_step
        gf2pa_step #(.W(W), .BASE(g * StepsPerStage)) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (pipe_valid[g]),
            .up_ready   (pipe_ready[g]),
            .up_ctrl    (pipe_ctrl[g]),
            .up_work    (pipe_work[g]),
            .up_x       (pipe_x[g]),
            .up_y       (pipe_y[g]),
            .up_s       (pipe_s[g]),
            .down_valid (pipe_valid[g+1]),
            .down_ready (pipe_ready[g+1]),
            .down_ctrl  (pipe_ctrl[g+1]),
            .down_work  (pipe_work[g+1]),
            .down_x     (pipe_x[g+1]),
            .down_y     (pipe_y[g+1]),
            .down_s     (pipe_s[g+1])
        );
    end

    // Divisor copy is only needed inside the step stages.
    gf2pa_finish #(.W(W)) u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (pipe_valid[NSTAGES]),
        .up_ready    (pipe_ready[NSTAGES]),
        .up_ctrl     (pipe_ctrl[NSTAGES]),
        .up_work     (pipe_work[NSTAGES]),
        .up_y        (pipe_y[NSTAGES]),
        .up_s        (pipe_s[NSTAGES]),
        .down_valid  (rsp.valid),
        .down_ready  (rsp.ready),
        .down_result (rsp.poly_result),
        .down_dz     (rsp.divide_by_zero)
    );

    // A division by zero always reports a zero polynomial.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.divide_by_zero |-> rsp.poly_result == '0)
        else $error("divide_by_zero result is not zero");

    // Nothing can land above the degree of a full product.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.poly_result >> (2*W-1)) == '0)
        else $error("result bits above product degree");

    // The quotient degree never exceeds the normalization shift.
    a_quo_degree: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid[NSTAGES] && pipe_ctrl[NSTAGES].op[1] && !pipe_ctrl[NSTAGES].dz
        |-> (({1'b0, pipe_y[NSTAGES]} >> pipe_s[NSTAGES]) >> 1) == '0)
        else $error("quotient wider than normalization allows");

    // Request side stalls only when every stage is full and the result is held.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid && !rsp.ready)
        else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for gf2_polynomial_alu: XOR, carry-less product and long division.
// Depends on gf2pa_pkg, gf2pa_req_if, gf2pa_rsp_if and the gf2_polynomial_alu RTL.
`default_nettype none

module tb_top;
    import gf2pa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One predicted answer per accepted request, in request order.
    typedef struct packed {
        logic [ResultWidth-1:0] poly;
        logic                   dz;
    } alu_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    gf2pa_req_if req ();
    gf2pa_rsp_if rsp ();

    gf2_polynomial_alu dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    alu_answer_t answers_due[$];
    int          mismatches = 0;

    // Idle control: calm is shared by both sides and turns all idling off for the
    // closing stretch; gap_pct sets how often the sender inserts a gap.
    bit calm    = 1'b0;
    int gap_pct = 20;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Carry-less product: XOR a shifted copy of a for every set bit of b.
    function automatic logic [ResultWidth-1:0] clmul32(logic [31:0] a, logic [31:0] b);
        logic [ResultWidth-1:0] acc;
        acc = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (b[i])
                acc ^= ResultWidth'(a) << i;
        end
        return acc;
    endfunction

    // Bitwise long division; divisor must be nonzero.
    function automatic void gf2_long_divide(input  logic [31:0] dividend,
                                            input  logic [31:0] divisor,
                                            output logic [31:0] quo,
                                            output logic [31:0] rem);
        int lead;
        lead = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (divisor[i])
                lead = i;
        end
        rem = dividend;
        quo = '0;
        // Walk the dividend from the top; cancel each leading term that
        // reaches the divisor's degree.
        for (int i = 31; i >= lead; i--)
        begin
            if (rem[i])
            begin
                rem ^= divisor << (i - lead);
                quo[i - lead] = 1'b1;
            end
        end
    endfunction

    function automatic alu_answer_t gf2_evaluate(opcode_t op, logic [31:0] a, logic [31:0] b);
        alu_answer_t ans;
        logic [31:0] quo;
        logic [31:0] rem;
        ans = '0;
        case (op)
            OP_ADD: ans.poly = ResultWidth'(a ^ b);
            OP_MUL: ans.poly = clmul32(a, b);
            default:
            begin
                if (b == '0)
                    ans.dz = 1'b1;
                else
                begin
                    gf2_long_divide(a, b, quo, rem);
                    ans.poly = (op == OP_REM) ? ResultWidth'(rem) : ResultWidth'(quo);
                end
            end
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Checker: sample both channels at the rising edge. Handle the result
    // side first so a same-edge request never masks an unexpected result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        alu_answer_t want;
        if (rst_n === 1'b1)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("poly_result: no result expected, got %h (divide_by_zero %b)",
                           rsp.poly_result, rsp.divide_by_zero);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.poly_result !== want.poly)
                    begin
                        $error("poly_result: expected %h, got %h", want.poly, rsp.poly_result);
                        mismatches++;
                    end
                    if (rsp.divide_by_zero !== want.dz)
                    begin
                        $error("divide_by_zero: expected %b, got %b",
                               want.dz, rsp.divide_by_zero);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
                answers_due.insert(answers_due.size(),
                                   gf2_evaluate(req.opcode, req.operand_a, req.operand_b));
        end
    end

    // ------------------------------------------------------------------
    // Result-side backpressure: random stalls, broken by quiet stretches
    // where ready stays high. Drive at the falling edge.
    // ------------------------------------------------------------------
    always
    begin
        int quiet_left;
        quiet_left = 0;
        rsp.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready = 1'b1;
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 19) == 0)
                quiet_left = $urandom_range(20, 200);
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp.ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                rsp.ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random polynomial with a spread of degrees, plus zero and single terms.
    function automatic logic [31:0] rand_poly();
        logic [31:0] v;
        int          deg;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = 32'h1 << $urandom_range(0, 31);
            2, 3:
            begin
                deg    = $urandom_range(0, 31);
                v      = v & (32'hFFFF_FFFF >> (31 - deg));
                v[deg] = 1'b1;
            end
            default: ;
        endcase
        return v;
    endfunction

    // Present one request and hold it until the transfer happens. An optional
    // gap with junk payload goes first; the valid stays high across
    // back-to-back calls.
    task automatic send_request(opcode_t op, logic [31:0] a, logic [31:0] b);
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            req.valid     = 1'b0;
            req.opcode    = opcode_t'($urandom_range(0, 3));
            req.operand_a = $urandom;
            req.operand_b = $urandom;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req.valid     = 1'b1;
        req.opcode    = op;
        req.operand_a = a;
        req.operand_b = b;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every opcode, zero divisors and short dividends.
    task automatic test_directed();
        send_request(OP_ADD, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_ADD, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
        send_request(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_MUL, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_MUL, 32'h1234_5678, 32'h0000_0001);
        send_request(OP_MUL, 32'h0000_0003, 32'h0000_0003);
        // Zero divisor: result zero, error flag set.
        send_request(OP_REM, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_QUO, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_REM, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_QUO, 32'h0000_0000, 32'h0000_0000);
        // Short dividend: quotient zero, remainder is the dividend.
        send_request(OP_REM, 32'h0000_0007, 32'h0000_0010);
        send_request(OP_QUO, 32'h0000_0007, 32'h0000_0010);
        send_request(OP_QUO, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(OP_REM, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(OP_QUO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_REM, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_QUO, 32'h8000_0000, 32'h0000_0003);
        send_request(OP_REM, 32'h8000_0000, 32'h0000_0003);
        send_request(OP_REM, 32'h0000_0000, 32'h8000_0000);
        send_request(OP_QUO, 32'hDEAD_BEEF, 32'h0000_011B);
        send_request(OP_REM, 32'hDEAD_BEEF, 32'h0000_011B);
    endtask

    // Random opcodes and operands; change the sender's gap rate every 100
    // items so some stretches run without gaps.
    task automatic test_random_traffic(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            send_request(opcode_t'($urandom_range(0, 3)), rand_poly(), rand_poly());
        end
    endtask

    // Closing stretch: no idling on either side, one transfer per cycle.
    task automatic test_full_rate(int count);
        calm = 1'b1;
        for (int n = 0; n < count; n++)
            send_request(opcode_t'($urandom_range(0, 3)), rand_poly(), rand_poly());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.opcode    = OP_ADD;
        req.operand_a = '0;
        req.operand_b = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(1500);
        test_full_rate(250);

        // Drop valid after the last transfer, drain, then wait for any stray
        // result to show up.
        @(negedge clk);
        req.valid = 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/gf2pa_pkg.sv
hdl/gf2pa_req_if.sv
hdl/gf2pa_rsp_if.sv
hdl/gf2pa_prep.sv
hdl/gf2pa_step.sv
hdl/gf2pa_finish.sv
hdl/gf2_polynomial_alu.sv
test/tb_top.sv
